/* rtl/pfa_pkg.sv */
// shared types and codes for the page frame allocator
package pfa_pkg;

  // request kinds carried on in_tuser
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_PAGE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_PAGE   = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_BAD_FREE  = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // commands into the recycle stack
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_ctrl_t;

  // flags out of the recycle stack
  typedef struct packed {
    logic empty;
    logic full;
    logic dup;
  } stack_flags_t;

endpackage

/* rtl/pfa_stack.sv */
// recycle stack: shifting register stack with a match compare per entry
module pfa_stack #(
  parameter int unsigned PAGE_NUM_BITS = 24,
  parameter int unsigned RECYCLE_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pfa_pkg::stack_ctrl_t      ctrl,
  input  logic [PAGE_NUM_BITS-1:0]  push_page,
  input  logic [PAGE_NUM_BITS-1:0]  probe_page,
  output logic [PAGE_NUM_BITS-1:0]  top_page,
  output pfa_pkg::stack_flags_t     flags
);

  localparam int unsigned CNT_BITS = $clog2(RECYCLE_DEPTH + 1);

  // entry 0 is the top of the stack
  logic [PAGE_NUM_BITS-1:0] entry_r   [RECYCLE_DEPTH];
  logic [PAGE_NUM_BITS-1:0] entry_nxt [RECYCLE_DEPTH];
  logic [CNT_BITS-1:0]      count_r;
  logic [CNT_BITS-1:0]      count_nxt;
  logic [RECYCLE_DEPTH-1:0] hit;

  always_comb begin
    for (int i = 0; i < RECYCLE_DEPTH; i++) begin
      hit[i] = (CNT_BITS'(i) < count_r) && (entry_r[i] == probe_page);
    end
  end

  assign top_page    = entry_r[0];
  assign flags.empty = (count_r == '0);
  assign flags.full  = (count_r == CNT_BITS'(RECYCLE_DEPTH));
  assign flags.dup   = |hit;

  always_comb begin
    for (int i = 0; i < RECYCLE_DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
      if (ctrl.push) begin
        entry_nxt[i] = (i == 0) ? push_page : entry_r[(i == 0) ? 0 : i - 1];
      end else if (ctrl.pop) begin
        entry_nxt[i] = (i == RECYCLE_DEPTH - 1) ? entry_r[i]
                                                : entry_r[(i == RECYCLE_DEPTH - 1) ? i : i + 1];
      end
    end
  end

  always_comb begin
    priority if (ctrl.clear) begin
      count_nxt = '0;
    end else if (ctrl.push) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_BITS'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RECYCLE_DEPTH; i++) begin
      entry_r[i] <= entry_nxt[i];
    end
  end

endmodule

/* rtl/page_frame_allocator.sv */
// page frame allocator top level: request register, decision logic, result register
//
//  channel | ports              | tdata            | tuser
//  --------+--------------------+------------------+-----------------
//  request | in_tvalid/tready   | page             | kind
//  result  | out_tvalid/tready  | page_out         | status
//  config  | cfg_we/index/wdata | register value   | -
//
// one request per cycle sustained while results are taken; a request waits in the
// request register, and its result enters the result register when it moves on;
// the duplicate check is one parallel compare over all recycle stack entries
// reset (synchronous, rst_n low) empties the stack and clears cursor and bounds
// a stalled result holds the result register; the request register keeps taking
// a transfer whenever its item moves on in the same cycle
module page_frame_allocator #(
  parameter int unsigned PAGE_NUM_BITS = 24,
  parameter int unsigned RECYCLE_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((PAGE_NUM_BITS+7)/8)*8-1:0] in_tdata,   // [PAGE_NUM_BITS-1:0] page
  input  logic                               in_tuser,   // [0] kind
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((PAGE_NUM_BITS+7)/8)*8-1:0] out_tdata,  // [PAGE_NUM_BITS-1:0] page_out
  output logic [1:0]                         out_tuser,  // [1:0] status
  // configuration write port
  input  logic                               cfg_we,
  input  logic [pfa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [PAGE_NUM_BITS-1:0]           cfg_wdata
);

  localparam int unsigned DATA_BITS = ((PAGE_NUM_BITS + 7) / 8) * 8;

  // request register
  logic                     req_valid_r;
  logic                     req_kind_r;
  logic [PAGE_NUM_BITS-1:0] req_page_r;

  // allocator state
  logic [PAGE_NUM_BITS-1:0] cursor_r;
  logic [PAGE_NUM_BITS-1:0] cursor_nxt;
  logic [PAGE_NUM_BITS-1:0] end_page_r;

  // result register
  logic                     res_valid_r;
  logic [PAGE_NUM_BITS-1:0] res_page_r;
  pfa_pkg::status_t         res_status_r;

  logic                     fire;
  logic [PAGE_NUM_BITS-1:0] dec_page;
  pfa_pkg::status_t         dec_status;
  pfa_pkg::stack_ctrl_t     stk_ctrl;
  pfa_pkg::stack_flags_t    stk_flags;
  logic [PAGE_NUM_BITS-1:0] stk_top;

  // the request moves on when the result register is free or being drained
  assign fire      = req_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !req_valid_r || fire;

  pfa_stack #(
    .PAGE_NUM_BITS (PAGE_NUM_BITS),
    .RECYCLE_DEPTH (RECYCLE_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (stk_ctrl),
    .push_page  (req_page_r),
    .probe_page (req_page_r),
    .top_page   (stk_top),
    .flags      (stk_flags)
  );

  // decision for the request in the request register
  always_comb begin
    dec_page       = '0;
    dec_status     = pfa_pkg::ST_OK;
    cursor_nxt     = cursor_r;
    stk_ctrl.push  = 1'b0;
    stk_ctrl.pop   = 1'b0;
    // writing start_page restarts the allocator with an empty stack
    stk_ctrl.clear = cfg_we && (cfg_index == pfa_pkg::REG_START_PAGE);
    if (req_kind_r == pfa_pkg::KIND_ALLOC) begin
      priority if (!stk_flags.empty) begin
        // most recently freed page first
        dec_page     = stk_top;
        stk_ctrl.pop = fire;
      end else if (cursor_r >= end_page_r) begin
        dec_status = pfa_pkg::ST_EXHAUSTED;
      end else begin
        dec_page   = cursor_r;
        cursor_nxt = cursor_r + PAGE_NUM_BITS'(1);
      end
    end else begin
      priority if ((req_page_r >= cursor_r) || stk_flags.dup) begin
        // never handed out, or already on the stack
        dec_status = pfa_pkg::ST_BAD_FREE;
      end else if (stk_flags.full) begin
        dec_status = pfa_pkg::ST_FULL;
      end else begin
        stk_ctrl.push = fire;
      end
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_tready) begin
      req_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_kind_r <= in_tuser;
      req_page_r <= in_tdata[PAGE_NUM_BITS-1:0];
    end
  end

  // cursor and bound
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      end_page_r <= '0;
    end else begin
      if (cfg_we && (cfg_index == pfa_pkg::REG_START_PAGE)) begin
        cursor_r <= cfg_wdata;
      end else if (fire) begin
        cursor_r <= cursor_nxt;
      end
      if (cfg_we && (cfg_index == pfa_pkg::REG_END_PAGE)) begin
        end_page_r <= cfg_wdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (fire) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_page_r   <= dec_page;
      res_status_r <= dec_status;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = DATA_BITS'(res_page_r);
  assign out_tuser  = res_status_r;

endmodule

/* rtl/pfa_checker.sv */
// port-level checker for the page frame allocator, bound to the top level
module pfa_checker #(
  parameter int unsigned DATA_BITS = 24
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [DATA_BITS-1:0] out_tdata,
  input logic [1:0]           out_tuser
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only a successful request carries a page number
  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != pfa_pkg::ST_OK) |-> out_tdata == '0)
    else $error("page number on a failed request");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // with an empty pipeline a request is always taken
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(rst_n) && !$past(in_tvalid && in_tready) |-> in_tready)
    else $error("request stalled while empty");

endmodule

bind page_frame_allocator pfa_checker #(
  .DATA_BITS (DATA_BITS)
) u_pfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* verif/tb.sv */
// self-checking testbench for page_frame_allocator with random requests, stalls and window changes
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PAGE_BITS    = 24;
  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned DATA_W       = ((PAGE_BITS + 7) / 8) * 8;
  localparam int unsigned TARGET_ITEMS = 900;
  // longest legal quiet stretch is one sender gap plus one receiver stall plus a register write pause
  localparam int unsigned QUIET_LIMIT  = 600;
  localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;

  typedef struct {
    logic                 kind;
    logic [PAGE_BITS-1:0] page;
  } request_t;

  typedef struct {
    logic [PAGE_BITS-1:0] page;
    pfa_pkg::status_t     status;
  } reply_t;

  // dut ports
  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [DATA_W-1:0]                in_tdata = '0;    // [23:0] page
  logic                             in_tuser = 1'b0;  // [0] kind
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [DATA_W-1:0]                out_tdata;        // [23:0] page_out
  logic [1:0]                       out_tuser;        // [1:0] status
  logic                             cfg_we = 1'b0;
  logic [pfa_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [PAGE_BITS-1:0]             cfg_wdata = '0;

  page_frame_allocator #(
    .PAGE_NUM_BITS(PAGE_BITS),
    .RECYCLE_DEPTH(STACK_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // shadow copy of the allocator: bounds, bump cursor and recycle stack
  logic [PAGE_BITS-1:0] start_m;
  logic [PAGE_BITS-1:0] end_m;
  logic [PAGE_BITS-1:0] cursor_m;
  logic [PAGE_BITS-1:0] pool [STACK_DEPTH];
  int                   pool_cnt;

  request_t pending_reqs[$];   // requests not yet offered on the input channel
  reply_t   replies_due[$];    // predicted results, oldest first
  int       err_count;
  int       issued;

  // driver and receiver bookkeeping
  bit       in_taken;
  bit       out_taken;
  bit       have_next;
  request_t next_req;
  int       tx_hold;
  int       rx_hold;
  int       tx_level;
  int       rx_level;
  int       quiet;

  initial begin
    start_m   = '0;
    end_m     = '0;
    cursor_m  = '0;
    pool_cnt  = 0;
    err_count = 0;
    issued    = 0;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    have_next = 1'b0;
    tx_hold   = 0;
    rx_hold   = 0;
    tx_level  = 1;
    rx_level  = 1;
    quiet     = 0;
  end

  // predicted result of one accepted request, updating the shadow state
  function automatic reply_t serve_request(request_t req);
    reply_t r;
    bit     seen;
    r.page   = '0;
    r.status = pfa_pkg::ST_OK;
    seen     = 1'b0;
    if (req.kind == pfa_pkg::KIND_ALLOC) begin
      if (pool_cnt > 0) begin
        // most recently freed page goes out first
        pool_cnt--;
        r.page = pool[pool_cnt];
      end else if (cursor_m >= end_m) begin
        r.status = pfa_pkg::ST_EXHAUSTED;
      end else begin
        r.page   = cursor_m;
        cursor_m = cursor_m + 1'b1;
      end
    end else begin
      for (int i = 0; i < pool_cnt; i++) begin
        if (pool[i] == req.page) seen = 1'b1;
      end
      if (req.page >= cursor_m || seen) begin
        r.status = pfa_pkg::ST_BAD_FREE;
      end else if (pool_cnt >= STACK_DEPTH) begin
        r.status = pfa_pkg::ST_FULL;
      end else begin
        pool[pool_cnt] = req.page;
        pool_cnt++;
      end
    end
    return r;
  endfunction

  // wait cycles for one transfer; level 0 never idles, level 1 now and then
  function automatic int draw_wait(int level);
    if (level == 0) return 0;
    if (level == 1) return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    return $urandom_range(0, 18);
  endfunction

  // request driver: each item waits its own gap before tvalid goes high
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (!have_next && pending_reqs.size() > 0) begin
          next_req  = pending_reqs.pop_front();
          have_next = 1'b1;
          if ($urandom_range(0, 39) == 0) tx_level = $urandom_range(0, 2);
          tx_hold = draw_wait(tx_level);
        end
        if (have_next && tx_hold == 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= next_req.kind;
          in_tdata  <= DATA_W'(next_req.page);
          have_next = 1'b0;
        end else begin
          if (have_next) tx_hold--;
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver: each result is held off for its own stall count
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) rx_level = $urandom_range(0, 2);
        rx_hold = draw_wait(rx_level);
      end
      out_tready <= (rx_hold == 0);
      if (rx_hold > 0 && out_tvalid) rx_hold--;
    end
  end

  // monitor: predict on every request transfer, check every result transfer
  always @(posedge clk) begin : monitor
    request_t seen_req;
    reply_t   want;
    bit       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_req.kind = in_tuser;
        seen_req.page = in_tdata[PAGE_BITS-1:0];
        replies_due.push_back(serve_request(seen_req));
        in_taken = 1'b1;
        moved    = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        moved     = 1'b1;
        if (replies_due.size() == 0) begin
          $error("unexpected result: page_out %0h status %0d", out_tdata[PAGE_BITS-1:0],
                 out_tuser);
          err_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_tdata[PAGE_BITS-1:0] !== want.page) begin
            $error("page_out mismatch: expected %0h actual %0h", want.page,
                   out_tdata[PAGE_BITS-1:0]);
            err_count++;
          end
          if (out_tuser !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, out_tuser);
            err_count++;
          end
        end
      end
      // watchdog on cycles without any transfer
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic push_req(input logic kind, input logic [PAGE_BITS-1:0] page);
    request_t r;
    r.kind = kind;
    r.page = page;
    pending_reqs.push_back(r);
    issued++;
  endtask

  // block until every request went out and every result came back
  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() > 0 || have_next || in_tvalid || replies_due.size() > 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // one register write; the shadow copy is updated when the write is driven
  task automatic write_reg(input logic [pfa_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [PAGE_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == pfa_pkg::REG_START_PAGE) begin
      start_m  = value;
      cursor_m = value;
      pool_cnt = 0;
    end else begin
      end_m = value;
    end
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic alloc_burst(input int n);
    // page field carries noise on allocates, the block ignores it
    for (int i = 0; i < n; i++) push_req(pfa_pkg::KIND_ALLOC, PAGE_BITS'($urandom()));
  endtask

  // frees scattered over the window and just past it, with some wild pages
  task automatic free_burst(input int n, input logic [PAGE_BITS-1:0] base, input int span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) push_req(pfa_pkg::KIND_FREE, PAGE_BITS'($urandom()));
      else push_req(pfa_pkg::KIND_FREE, base + PAGE_BITS'($urandom_range(0, span + 3)));
    end
  endtask

  // hand out the whole window, give it back in random order, then take some or all of it again
  // this mostly well-formed path, with an occasional double free, can drive the recycle stack to full
  task automatic fill_drain(input logic [PAGE_BITS-1:0] base, input int span);
    logic [PAGE_BITS-1:0] order[$];
    logic [PAGE_BITS-1:0] tmp;
    int                   j;
    alloc_burst(span + 2);
    for (int i = 0; i < span; i++) order.push_back(base + PAGE_BITS'(i));
    for (int i = order.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) begin
      push_req(pfa_pkg::KIND_FREE, order[i]);
      if ($urandom_range(0, 11) == 0) push_req(pfa_pkg::KIND_FREE, order[$urandom_range(0, i)]);
    end
    alloc_burst($urandom_range(1, 70));
  endtask

  initial begin : stimulus
    logic [PAGE_BITS-1:0] win_base;
    logic [PAGE_BITS-1:0] win_end;
    longint               hi;
    int                   win_span;
    int                   phase_len;
    int                   phase_start;
    int                   pick;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    wait_idle();

    // directed: empty window straight out of reset
    push_req(pfa_pkg::KIND_ALLOC, '0);
    push_req(pfa_pkg::KIND_FREE, '0);
    push_req(pfa_pkg::KIND_FREE, PAGE_MAX);
    wait_idle();

    // three page window at zero: exhaustion, double free, free past cursor, lifo reuse
    write_reg(pfa_pkg::REG_END_PAGE, PAGE_BITS'(3));
    end_writes();
    alloc_burst(4);
    push_req(pfa_pkg::KIND_FREE, PAGE_BITS'(1));
    push_req(pfa_pkg::KIND_FREE, PAGE_BITS'(1));
    push_req(pfa_pkg::KIND_FREE, PAGE_BITS'(3));
    push_req(pfa_pkg::KIND_FREE, '0);
    alloc_burst(3);
    wait_idle();

    // window at the top of the page space
    write_reg(pfa_pkg::REG_START_PAGE, PAGE_MAX - 1'b1);
    write_reg(pfa_pkg::REG_END_PAGE, PAGE_MAX);
    end_writes();
    alloc_burst(2);
    push_req(pfa_pkg::KIND_FREE, PAGE_MAX);
    push_req(pfa_pkg::KIND_FREE, PAGE_MAX - 1'b1);
    push_req(pfa_pkg::KIND_FREE, '0);
    push_req(pfa_pkg::KIND_ALLOC, PAGE_MAX);
    wait_idle();

    // shrinking the bound keeps the stack, pops still succeed
    write_reg(pfa_pkg::REG_END_PAGE, '0);
    end_writes();
    alloc_burst(2);
    wait_idle();

    // random phases, each behind a fresh window setting
    win_base = '0;
    win_span = 0;
    issued   = 0;
    while (issued < TARGET_ITEMS) begin
      pick = $urandom_range(0, 7);
      if (pick == 0 && win_span > 0) begin
        // move only the bound, stack and cursor stay
        win_span = $urandom_range(0, 95);
        hi       = longint'(win_base) + win_span;
        win_end  = (hi > longint'(PAGE_MAX)) ? PAGE_MAX : PAGE_BITS'(hi);
        write_reg(pfa_pkg::REG_END_PAGE, win_end);
      end else begin
        case ($urandom_range(0, 3))
          0:       win_base = PAGE_BITS'($urandom_range(0, 20));
          1:       win_base = PAGE_MAX - PAGE_BITS'($urandom_range(0, 100));
          default: win_base = PAGE_BITS'($urandom());
        endcase
        win_span = (pick < 3) ? $urandom_range(66, 96) : $urandom_range(0, 95);
        hi       = longint'(win_base) + win_span;
        win_end  = (hi > longint'(PAGE_MAX)) ? PAGE_MAX : PAGE_BITS'(hi);
        // now and then a bound below the start
        if (pick == 7) win_end = (win_base > 5) ? win_base - PAGE_BITS'($urandom_range(1, 5)) : '0;
        if ($urandom_range(0, 1) == 0) begin
          write_reg(pfa_pkg::REG_START_PAGE, win_base);
          write_reg(pfa_pkg::REG_END_PAGE, win_end);
        end else begin
          write_reg(pfa_pkg::REG_END_PAGE, win_end);
          write_reg(pfa_pkg::REG_START_PAGE, win_base);
        end
      end
      end_writes();

      if (pick < 3 && win_end > win_base) fill_drain(win_base, int'(win_end - win_base));
      phase_len   = $urandom_range(60, 160);
      phase_start = issued;
      while (issued - phase_start < phase_len) begin
        case ($urandom_range(0, 2))
          0:       alloc_burst($urandom_range(1, win_span + 4));
          1:       free_burst($urandom_range(1, 40), win_base, win_span);
          default: begin
            for (int i = 0; i < 10; i++) begin
              if ($urandom_range(0, 1) == 0) alloc_burst(1);
              else free_burst(1, win_base, win_span);
            end
          end
        endcase
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0 && replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
